### src/playback_ring_writer_with_resync_unit_assert.svh
// Assertion helpers for the playback ring writer.
`ifndef PLAYBACK_RING_WRITER_WITH_RESYNC_UNIT_ASSERT_SVH
`define PLAYBACK_RING_WRITER_WITH_RESYNC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising edge outside reset
`define PRWR_ASSERT_IMPLIES(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("ring writer check failed: same-cycle implication");

// Next-cycle implication, checked on the rising edge outside reset
`define PRWR_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("ring writer check failed: next-cycle implication");

`else

`define PRWR_ASSERT_IMPLIES(name, clk, rst_n, cond, prop)
`define PRWR_ASSERT_NEXT(name, clk, rst_n, cond, prop)

`endif

`endif

### src/prwr_pkg.sv
`default_nettype none

package prwr_pkg;

	// Ring geometry
	localparam int RING_BYTES  = 4096;
	localparam int NUM_CHUNKS  = 32;
	localparam int CHUNK_BYTES = RING_BYTES / NUM_CHUNKS;
	localparam int AW          = $clog2(RING_BYTES);
	localparam int CHUNK_W     = $clog2(CHUNK_BYTES);
	localparam int CIDX_W      = $clog2(NUM_CHUNKS);
	localparam int CNT_W       = AW + 1;
	localparam int DATA_W      = 8;

	// Configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AHEAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR     = 2'd2;
	localparam logic [CFG_W-1:0] LEAD_RST      = 5'd4;
	localparam logic [CFG_W-1:0] MAX_AHEAD_RST = 5'd12;
	localparam logic [CFG_W-1:0] CLEAR_RST     = 5'd2;

	// Command queue
	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_SYNC  = 2'd0,
		OP_WRITE = 2'd1,
		OP_STOP  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_READ,
		CMD_CLEAR_ALL,
		CMD_CLEAR_SPAN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [AW-1:0]     addr;
		logic [DATA_W-1:0] data;
		logic [AW-1:0]     span;
		logic [AW-1:0]     wpos;
		logic              resynced;
		logic              burst_done;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
	} bk_status_t;

	typedef enum logic [1:0] {
		BK_INIT,
		BK_RUN,
		BK_SWEEP
	} bk_state_t;

endpackage

`default_nettype wire

### src/prwr_ram.sv
`default_nettype none

module prwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/prwr_queue.sv
`default_nettype none

module prwr_queue
	import prwr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t             entries_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == QCW'(QDEPTH));

endmodule

`default_nettype wire

### src/prwr_front.sv
`default_nettype none

module prwr_front
	import prwr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           op,
	input  wire logic [CIDX_W-1:0]    reader_chunk,
	input  wire logic [DATA_W-1:0]    byte_in,
	input  wire logic [AW-1:0]        read_addr,
	input  wire logic                 last_in_burst,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 q_full,
	input  wire bk_status_t           bk_st,
	output logic                      push,
	output cmd_t                      push_cmd
);

	logic [CFG_W-1:0]  lead_q;
	logic [CFG_W-1:0]  max_ahead_q;
	logic [CFG_W-1:0]  clear_q;
	logic [AW-1:0]     wp_q;
	logic              running_q;

	logic [AW-1:0]     reader_base;
	logic [AW-1:0]     ahead;
	logic [AW-1:0]     far_lim;
	logic [CIDX_W-1:0] new_chunk;
	logic [AW-1:0]     new_wp;
	logic [AW-1:0]     wp_inc;
	logic              out_of_window;
	cmd_t              cmd;
	logic [AW-1:0]     wp_d;
	logic              running_d;

	assign cfg_ready = 1'b1;
	assign busy      = q_full | bk_st.init_busy;
	assign push      = start & ~busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q      <= LEAD_RST;
			max_ahead_q <= MAX_AHEAD_RST;
			clear_q     <= CLEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEAD:      lead_q      <= cfg_data;
				CFG_MAX_AHEAD: max_ahead_q <= cfg_data;
				CFG_CLEAR:     clear_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Reader distance and restart position
	assign reader_base   = {reader_chunk, CHUNK_W'(0)};
	assign ahead         = wp_q - reader_base;
	assign far_lim       = AW'({max_ahead_q, CHUNK_W'(0)});
	assign new_chunk     = reader_chunk + lead_q;
	assign new_wp        = {new_chunk, CHUNK_W'(0)};
	assign wp_inc        = wp_q + AW'(1);
	assign out_of_window = (ahead > far_lim) || (ahead < AW'(CHUNK_BYTES / 2));

	// Classify the item into a back-end command
	always_comb begin
		cmd            = '0;
		cmd.kind       = CMD_NONE;
		cmd.wpos       = wp_q;
		wp_d           = wp_q;
		running_d      = running_q;
		unique case (op_t'(op))
			OP_SYNC: begin
				if (!running_q) begin
					cmd.kind     = CMD_CLEAR_ALL;
					cmd.resynced = 1'b1;
					cmd.wpos     = new_wp;
					wp_d         = new_wp;
					running_d    = 1'b1;
				end else if (out_of_window) begin
					cmd.kind     = CMD_CLEAR_SPAN;
					cmd.addr     = new_wp;
					cmd.span     = AW'({clear_q, CHUNK_W'(0)});
					cmd.resynced = 1'b1;
					cmd.wpos     = new_wp;
					wp_d         = new_wp;
				end
			end
			OP_WRITE: begin
				cmd.kind       = CMD_WRITE;
				cmd.addr       = wp_q;
				cmd.data       = byte_in;
				cmd.burst_done = last_in_burst;
				cmd.wpos       = wp_inc;
				wp_d           = wp_inc;
			end
			OP_STOP: begin
				cmd.kind  = CMD_CLEAR_ALL;
				cmd.wpos  = '0;
				wp_d      = '0;
				running_d = 1'b0;
			end
			OP_READ: begin
				cmd.kind = CMD_READ;
				cmd.addr = read_addr;
			end
			default: ;
		endcase
	end

	assign push_cmd = cmd;

	// Write position and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			running_q <= 1'b0;
		end else if (push) begin
			wp_q      <= wp_d;
			running_q <= running_d;
		end
	end

endmodule

`default_nettype wire

### src/prwr_back.sv
`default_nettype none

module prwr_back
	import prwr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  wire cmd_t         head,
	output logic              pop,
	output bk_status_t        bk_st,
	output logic              done,
	output logic [DATA_W-1:0] data_out,
	output logic [AW-1:0]     write_position,
	output logic              resynced,
	output logic              burst_done
);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [AW-1:0]     sweep_addr_q;
	logic [CNT_W-1:0]  sweep_cnt_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic              re;
	logic [DATA_W-1:0] rdata;

	logic              done_s1;
	logic              rd_s1;
	logic [AW-1:0]     wpos_s1;
	logic              resynced_s1;
	logic              burst_done_s1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		we      = 1'b0;
		waddr   = sweep_addr_q;
		wdata   = '0;
		re      = 1'b0;
		unique case (state_q)
			BK_INIT: begin
				we = 1'b1;
				if (sweep_cnt_q == CNT_W'(1)) begin
					state_d = BK_RUN;
				end
			end
			BK_SWEEP: begin
				we = 1'b1;
				if (sweep_cnt_q == CNT_W'(1)) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (!q_empty) begin
					pop = 1'b1;
					case (head.kind)
						CMD_WRITE: begin
							we    = 1'b1;
							waddr = head.addr;
							wdata = head.data;
						end
						CMD_READ: re = 1'b1;
						CMD_CLEAR_ALL: state_d = BK_SWEEP;
						CMD_CLEAR_SPAN: begin
							if (head.span != '0) begin
								state_d = BK_SWEEP;
							end
						end
						default: ;
					endcase
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	// Zero sweep address and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_cnt_q  <= CNT_W'(RING_BYTES);
		end else if (state_q == BK_INIT || state_q == BK_SWEEP) begin
			sweep_addr_q <= sweep_addr_q + AW'(1);
			sweep_cnt_q  <= sweep_cnt_q - CNT_W'(1);
		end else if (pop && head.kind == CMD_CLEAR_ALL) begin
			sweep_addr_q <= '0;
			sweep_cnt_q  <= CNT_W'(RING_BYTES);
		end else if (pop && head.kind == CMD_CLEAR_SPAN) begin
			sweep_addr_q <= head.addr;
			sweep_cnt_q  <= {1'b0, head.span};
		end
	end

	prwr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (head.addr),
		.rdata (rdata)
	);

	// Result strobe stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			rd_s1   <= 1'b0;
		end else begin
			done_s1 <= pop;
			rd_s1   <= pop && head.kind == CMD_READ;
		end
	end

	// Result payload stage
	always_ff @(posedge clk) begin
		if (pop) begin
			wpos_s1       <= head.wpos;
			resynced_s1   <= head.resynced;
			burst_done_s1 <= head.burst_done;
		end
	end

	assign bk_st.init_busy = (state_q == BK_INIT);
	assign done            = done_s1;
	assign data_out        = rd_s1 ? rdata : '0;
	assign write_position  = wpos_s1;
	assign resynced        = resynced_s1;
	assign burst_done      = burst_done_s1;

endmodule

`default_nettype wire

### src/playback_ring_writer_with_resync_unit.sv
// A result strobes on done once its item has passed the command queue and the result strobe stage.
// Throughput: write, read and in-window sync items sustain 1 item per cycle while busy stays low.
// A starting sync or a stop zeroes all 4096 bytes of the ring; a resync zeroes
// clear_chunks * 128 bytes from the new write position; the sweep uses the one memory write port.
// Reset: arst_n clears control at once, then a zero sweep over all 4096 bytes runs with busy high.
// Results are single-cycle strobes on done; the receiver cannot stall them.
`default_nettype none

`include "playback_ring_writer_with_resync_unit_assert.svh"

module playback_ring_writer_with_resync_unit
	import prwr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           op,
	input  wire logic [4:0]           reader_chunk,
	input  wire logic [7:0]           byte_in,
	input  wire logic [11:0]          read_addr,
	input  wire logic                 last_in_burst,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [4:0]           cfg_data,
	output logic                      done,
	output logic [7:0]                data_out,
	output logic [11:0]               write_position,
	output logic                      resynced,
	output logic                      burst_done
);

	logic       q_push;
	cmd_t       q_push_cmd;
	logic       q_pop;
	cmd_t       q_head;
	logic       q_empty;
	logic       q_full;
	bk_status_t bk_st;

	// Accept and classify items
	prwr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.reader_chunk  (reader_chunk),
		.byte_in       (byte_in),
		.read_addr     (read_addr),
		.last_in_burst (last_in_burst),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (q_full),
		.bk_st         (bk_st),
		.push          (q_push),
		.push_cmd      (q_push_cmd)
	);

	// Decouple front and back
	prwr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Execute commands against the ring
	prwr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (q_head),
		.pop            (q_pop),
		.bk_st          (bk_st),
		.done           (done),
		.data_out       (data_out),
		.write_position (write_position),
		.resynced       (resynced),
		.burst_done     (burst_done)
	);

	// Checks
	`PRWR_ASSERT_IMPLIES(a_init_holds_input, clk, arst_n, bk_st.init_busy, busy)
	`PRWR_ASSERT_IMPLIES(a_no_result_in_init, clk, arst_n, bk_st.init_busy, !done)
	`PRWR_ASSERT_NEXT(a_pop_gives_result, clk, arst_n, q_pop, done)
	`PRWR_ASSERT_IMPLIES(a_burst_not_resync, clk, arst_n, done && burst_done, !resynced)

endmodule

`default_nettype wire
